// ===== hdl/hsps_pkg.sv =====
// ----------------------------------------------------------------------------
// hsps_pkg
// Types and constants shared by the humidity sensor poll sequencer.
// ----------------------------------------------------------------------------
package hsps_pkg;

  // bus action codes reported per poll
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_TRIGGER = 2'd1;
  localparam logic [1:0] ACT_STATUS  = 2'd2;
  localparam logic [1:0] ACT_FRAME   = 2'd3;

  localparam int unsigned BUSY_BIT = 7;

  localparam logic [31:0] SETTLE_MS      = 32'd90;
  localparam logic [1:0]  MAX_READ_TRIES = 2'd3;
  localparam logic [2:0]  FAIL_LIMIT     = 3'd5;
  localparam logic [2:0]  FAIL_SAT       = 3'd6;

  localparam logic [15:0] PERIOD_RESET   = 16'd1000;
  localparam logic [19:0] STALE_BASE_MS  = 20'd5000;
  localparam logic [19:0] STALE_RESET    = 20'd15000;

  // valid temperature window -40..90 degC expressed on the 20-bit raw code
  localparam logic [19:0] RAW_T_MIN = 20'd52429;
  localparam logic [19:0] RAW_T_MAX = 20'd734003;

  // scale factors to hundredths over 2^20
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [14:0] TEMP_SCALE  = 15'd20000;
  localparam logic [15:0] TEMP_OFFSET = 16'd5000;

  typedef struct packed {
    logic        busy;
    logic        in_range;
    logic [13:0] humidity;
    logic [14:0] temperature;
  } frame_info_t;

endpackage

// ===== hdl/humidity_sensor_poll_sequencer.sv =====
// ----------------------------------------------------------------------------
// humidity_sensor_poll_sequencer
// Poll sequencer for an I2C humidity and temperature sensor.
// ----------------------------------------------------------------------------
// Each input transfer is one poll: a millisecond timestamp plus the outcome of
// every bus transfer that poll would make. Each poll yields exactly one result
// transfer with the bus action taken, the fresh-data flag, the health flag and
// the last stored humidity and temperature.
// Input channel in_*, result channel out_*, period register via cfg_wr_en and
// cfg_wr_data (write only while no poll is in flight).
// A poll accepted is held in the input register, and its result is loaded into
// the output register when the output register is empty or being drained. One
// poll per cycle is sustained while out_tready stays high, set by the
// combinational state update between the two registers.
// When out_tready is low the output register holds its result and the input
// register still takes one more poll; in_tready then drops until the result
// is taken.
// Reset (rst_n low, synchronous) puts the sequencer in idle, clears all times,
// counters, flags and stored readings, and loads a period of 1000 ms.
// ----------------------------------------------------------------------------
module humidity_sensor_poll_sequencer
  import hsps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,   // period_ms
  input  logic        in_tvalid,
  output logic        in_tready,
  // now_ms[31:0], trigger_acked[32], status_received[33], status_byte[41:34],
  // frame_complete[42], frame_bytes[90:43], zero fill[95:91]
  input  logic [95:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // bus_action[1:0], new_data[2], sensor_ok[3], reading_valid[4],
  // humidity_centi[18:5], temperature_centi[33:19], zero fill[39:34]
  output logic [39:0] out_tdata
);

  logic        in_valid_r;
  logic [90:0] in_data_r;
  logic        out_valid_r;
  logic [33:0] out_data_r;
  logic        advance;

  logic [15:0] period_r;
  logic [19:0] stale_limit_r;

  logic        measuring_r,   measuring_nxt;
  logic [31:0] last_req_r,    last_req_nxt;
  logic [31:0] last_good_r,   last_good_nxt;
  logic [1:0]  attempts_r,    attempts_nxt;
  logic [2:0]  fail_cnt_r,    fail_cnt_nxt;
  logic        healthy_r,     healthy_nxt;
  logic [13:0] humidity_r,    humidity_nxt;
  logic [14:0] temperature_r, temperature_nxt;
  logic        has_reading_r, has_reading_nxt;

  logic [31:0] now_ms;
  logic        trigger_acked;
  logic        status_received;
  logic [7:0]  status_byte;
  logic        frame_complete;
  logic [47:0] frame_bytes;

  logic [1:0]  action;
  logic        fresh;
  logic        fail;
  logic [1:0]  attempts_inc;
  logic [31:0] since_req;
  logic [31:0] since_good;
  frame_info_t info;

  assign now_ms          = in_data_r[31:0];
  assign trigger_acked   = in_data_r[32];
  assign status_received = in_data_r[33];
  assign status_byte     = in_data_r[41:34];
  assign frame_complete  = in_data_r[42];
  assign frame_bytes     = in_data_r[90:43];

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  hsps_frame_decode u_decode (
    .frame_bytes (frame_bytes),
    .info        (info)
  );

  assign since_req    = now_ms - last_req_r;
  assign attempts_inc = attempts_r + 2'd1;

  always_comb begin
    measuring_nxt   = measuring_r;
    last_req_nxt    = last_req_r;
    last_good_nxt   = last_good_r;
    attempts_nxt    = attempts_r;
    fail_cnt_nxt    = fail_cnt_r;
    healthy_nxt     = healthy_r;
    humidity_nxt    = humidity_r;
    temperature_nxt = temperature_r;
    has_reading_nxt = has_reading_r;
    action          = ACT_NONE;
    fresh           = 1'b0;
    fail            = 1'b0;

    if (!measuring_r) begin
      if (since_req >= {16'd0, period_r}) begin
        action       = ACT_TRIGGER;
        last_req_nxt = now_ms;
        if (trigger_acked) begin
          measuring_nxt = 1'b1;
        end else begin
          fail = 1'b1;
        end
      end
    end else if (since_req >= SETTLE_MS) begin
      action = ACT_STATUS;
      if (!status_received) begin
        if (attempts_inc >= MAX_READ_TRIES) begin
          attempts_nxt  = 2'd0;
          measuring_nxt = 1'b0;
          last_req_nxt  = now_ms;
          fail          = 1'b1;
        end else begin
          attempts_nxt = attempts_inc;
        end
      end else begin
        attempts_nxt = 2'd0;
        if (!status_byte[BUSY_BIT]) begin
          action        = ACT_FRAME;
          measuring_nxt = 1'b0;
          last_req_nxt  = now_ms;
          if (frame_complete && !info.busy && info.in_range) begin
            fresh           = 1'b1;
            fail_cnt_nxt    = 3'd0;
            healthy_nxt     = 1'b1;
            last_good_nxt   = now_ms;
            humidity_nxt    = info.humidity;
            temperature_nxt = info.temperature;
            has_reading_nxt = 1'b1;
          end else begin
            fail = 1'b1;
          end
        end
      end
    end

    if (fail) begin
      if (fail_cnt_r < FAIL_SAT) begin
        fail_cnt_nxt = fail_cnt_r + 3'd1;
      end
      if (fail_cnt_nxt > FAIL_LIMIT) begin
        healthy_nxt = 1'b0;
      end
    end

    // staleness uses the time of the last good reading after this poll
    since_good = now_ms - last_good_nxt;
    if (healthy_nxt && (since_good > {12'd0, stale_limit_r})) begin
      healthy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r      <= PERIOD_RESET;
      stale_limit_r <= STALE_RESET;
    end else if (cfg_wr_en) begin
      period_r      <= cfg_wr_data;
      stale_limit_r <= ({4'd0, cfg_wr_data} << 3) + ({4'd0, cfg_wr_data} << 1)
                       + STALE_BASE_MS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata[90:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {temperature_nxt, humidity_nxt, has_reading_nxt,
                     healthy_nxt, fresh, action};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      measuring_r   <= 1'b0;
      last_req_r    <= 32'd0;
      last_good_r   <= 32'd0;
      attempts_r    <= 2'd0;
      fail_cnt_r    <= 3'd0;
      healthy_r     <= 1'b0;
      humidity_r    <= 14'd0;
      temperature_r <= 15'd0;
      has_reading_r <= 1'b0;
    end else if (advance) begin
      measuring_r   <= measuring_nxt;
      last_req_r    <= last_req_nxt;
      last_good_r   <= last_good_nxt;
      attempts_r    <= attempts_nxt;
      fail_cnt_r    <= fail_cnt_nxt;
      healthy_r     <= healthy_nxt;
      humidity_r    <= humidity_nxt;
      temperature_r <= temperature_nxt;
      has_reading_r <= has_reading_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_data_r};

endmodule

// ===== hdl/hsps_frame_decode.sv =====
// ----------------------------------------------------------------------------
// hsps_frame_decode
// Unpacks the six-byte result frame, range-checks the temperature code and
// converts both raw fields to hundredths.
// ----------------------------------------------------------------------------
module hsps_frame_decode
  import hsps_pkg::*;
(
  input  logic [47:0]  frame_bytes,
  output frame_info_t  info
);

  logic [19:0] raw_h;
  logic [19:0] raw_t;
  logic [33:0] hum_prod;
  logic [34:0] temp_prod;
  logic [15:0] temp_wide;

  // byte 0 sits in the top bits
  assign raw_h = {frame_bytes[39:32], frame_bytes[31:24], frame_bytes[23:20]};
  assign raw_t = {frame_bytes[19:16], frame_bytes[15:8], frame_bytes[7:0]};

  assign hum_prod  = raw_h * HUM_SCALE;
  assign temp_prod = raw_t * TEMP_SCALE;
  assign temp_wide = {1'b0, temp_prod[34:20]} - TEMP_OFFSET;

  assign info.busy        = frame_bytes[40 + BUSY_BIT];
  assign info.in_range    = (raw_t >= RAW_T_MIN) && (raw_t <= RAW_T_MAX);
  assign info.humidity    = hum_prod[33:20];
  assign info.temperature = temp_wide[14:0];

endmodule

// ===== hdl/hsps_checker.sv =====
// ----------------------------------------------------------------------------
// hsps_checker
// Port-level assertions for the humidity sensor poll sequencer.
// ----------------------------------------------------------------------------
module hsps_checker
  import hsps_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_wr_en,
  input logic [15:0] cfg_wr_data,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [95:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  logic signed [14:0] temp_field;
  assign temp_field = $signed(out_tdata[33:19]);

  // a stalled result keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

  // fresh data only comes with a frame read and leaves the block healthy
  a_fresh_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |->
      out_tdata[1:0] == ACT_FRAME && out_tdata[3] && out_tdata[4])
    else $error("fresh data without frame read or health");

  // a fresh reading lies in the converted ranges
  a_fresh_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |->
      out_tdata[18:5] <= 14'd9999 && temp_field >= -15'sd4000 &&
      temp_field <= 15'sd9000)
    else $error("fresh reading out of range");

  // no input is taken while both registers are full and the output stalls
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready && !in_tready |=> !in_tready || out_tready ||
      !out_tvalid || $past(out_tready))
    else $error("input taken while blocked");

  logic unused_ok;
  assign unused_ok = cfg_wr_en ^ (|cfg_wr_data) ^ in_tvalid ^ (|in_tdata);

endmodule

bind humidity_sensor_poll_sequencer hsps_checker u_hsps_checker (.*);

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the humidity sensor poll sequencer.
// ----------------------------------------------------------------------------
// Streams timestamped polls into the sequencer and checks every result
// transfer against a cycle-free model of the poll state machine: trigger,
// settle wait, status retries, frame decode, failure counting and staleness.
// A directed run walks each failure path and the conversion extremes. Random
// phases follow under different trigger periods and fault rates. Both stream
// sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import hsps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned PHASE_POLLS  = 265;
  localparam int unsigned REPORT_LINES = 40;

  // one poll, first field in the low bits
  typedef struct packed {
    logic [4:0]  fill;
    logic [47:0] frame_bytes;
    logic        frame_complete;
    logic [7:0]  status_byte;
    logic        status_received;
    logic        trigger_acked;
    logic [31:0] now_ms;
  } poll_t;

  typedef struct packed {
    logic [5:0]         fill;
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    logic               reading_valid;
    logic               sensor_ok;
    logic               new_data;
    logic [1:0]         bus_action;
  } poll_report_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  humidity_sensor_poll_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // sequencer model state
  logic [15:0]        seq_period;
  logic               seq_measuring;
  logic [31:0]        seq_last_request;
  logic [31:0]        seq_last_good;
  logic [1:0]         seq_attempts;
  logic [2:0]         seq_failures;
  logic               seq_healthy;
  logic [13:0]        seq_humidity;
  logic signed [14:0] seq_temperature;
  logic               seq_has_reading;

  poll_t        queued_polls[$];
  poll_report_t awaited_reports[$];

  int unsigned polls_queued;
  int unsigned polls_accepted;
  int unsigned reports_checked;
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned action_count[4];
  int unsigned fresh_count;
  int unsigned stale_drops;

  logic        in_fire_seen;
  logic        out_fire_seen;
  int unsigned in_gap;
  int unsigned out_stall;
  bit          in_calm;
  bit          out_calm;
  logic [31:0] gen_now;

  function automatic void note_failure();
    if (seq_failures < FAIL_SAT) seq_failures = seq_failures + 3'd1;
    if (seq_failures > FAIL_LIMIT) seq_healthy = 1'b0;
  endfunction

  // frame decode; stores the reading only when it passes the checks
  function automatic bit decode_reading(logic [47:0] frame);
    logic [19:0] raw_h;
    logic [19:0] raw_t;
    logic [63:0] t200;
    raw_h = frame[39:20];
    raw_t = frame[19:0];
    t200  = 64'(raw_t) * 64'd200;
    if (frame[47]) return 1'b0;
    if (t200 < 64'd10 * 64'd1048576 || t200 > 64'd140 * 64'd1048576) return 1'b0;
    seq_humidity    = 14'((64'(raw_h) * 64'd10000) >> 20);
    seq_temperature = 15'(int'((64'(raw_t) * 64'd20000) >> 20) - 5000);
    seq_has_reading = 1'b1;
    return 1'b1;
  endfunction

  function automatic poll_report_t advance_sequencer(poll_t p);
    poll_report_t r;
    r = '0;
    r.bus_action = ACT_NONE;
    if (!seq_measuring) begin
      if (p.now_ms - seq_last_request >= 32'(seq_period)) begin
        r.bus_action = ACT_TRIGGER;
        seq_last_request = p.now_ms;
        if (p.trigger_acked) seq_measuring = 1'b1;
        else note_failure();
      end
    end else if (p.now_ms - seq_last_request >= SETTLE_MS) begin
      r.bus_action = ACT_STATUS;
      if (!p.status_received) begin
        seq_attempts = seq_attempts + 2'd1;
        if (seq_attempts >= MAX_READ_TRIES) begin
          seq_attempts = '0;
          seq_measuring = 1'b0;
          seq_last_request = p.now_ms;
          note_failure();
        end
      end else begin
        seq_attempts = '0;
        if (!p.status_byte[BUSY_BIT]) begin
          r.bus_action = ACT_FRAME;
          if (p.frame_complete && decode_reading(p.frame_bytes)) begin
            seq_failures = '0;
            seq_healthy = 1'b1;
            seq_last_good = p.now_ms;
            r.new_data = 1'b1;
          end else begin
            note_failure();
          end
          seq_measuring = 1'b0;
          seq_last_request = p.now_ms;
        end
      end
    end
    if (seq_healthy && (p.now_ms - seq_last_good > 32'(seq_period) * 32'd10 + 32'd5000)) begin
      seq_healthy = 1'b0;
      stale_drops++;
    end
    r.sensor_ok         = seq_healthy;
    r.reading_valid     = seq_has_reading;
    r.humidity_centi    = seq_humidity;
    r.temperature_centi = seq_temperature;
    return r;
  endfunction

  task automatic report_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= REPORT_LINES)
      $display("%0t: mismatch on %s: expected %0d, got %0d (result %0d)",
               $realtime, what, want, got, reports_checked);
  endtask

  task automatic check_report(poll_report_t got);
    poll_report_t want;
    if (awaited_reports.size() == 0) begin
      report_mismatch("result with none pending", 0, int'(got.bus_action));
      return;
    end
    want = awaited_reports.pop_front();
    if (got.bus_action != want.bus_action)
      report_mismatch("bus_action", want.bus_action, got.bus_action);
    if (got.new_data != want.new_data)
      report_mismatch("new_data", want.new_data, got.new_data);
    if (got.sensor_ok != want.sensor_ok)
      report_mismatch("sensor_ok", want.sensor_ok, got.sensor_ok);
    if (got.reading_valid != want.reading_valid)
      report_mismatch("reading_valid", want.reading_valid, got.reading_valid);
    if (got.humidity_centi != want.humidity_centi)
      report_mismatch("humidity_centi", want.humidity_centi, got.humidity_centi);
    if (got.temperature_centi != want.temperature_centi)
      report_mismatch("temperature_centi", int'(want.temperature_centi),
                      int'(got.temperature_centi));
    action_count[want.bus_action]++;
    if (want.new_data) fresh_count++;
    reports_checked++;
  endtask

  // wait per transfer, with runs of back-to-back transfers now and then
  function automatic int unsigned draw_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic bit chance(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // monitor, model update and watchdog count
  always @(posedge clk) begin
    in_fire_seen  <= rst_n && in_tvalid && in_tready;
    out_fire_seen <= rst_n && out_tvalid && out_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) check_report(out_tdata);
      if (in_tvalid && in_tready) begin
        awaited_reports.push_back(advance_sequencer(in_tdata));
        polls_accepted++;
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // poll driver
  always @(negedge clk) begin
    if (rst_n && (in_fire_seen || !in_tvalid)) begin
      if (in_fire_seen) in_gap = draw_wait(in_calm);
      if (in_gap != 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (queued_polls.size() != 0) begin
        in_tdata  <= queued_polls.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result side backpressure
  always @(negedge clk) begin
    if (out_fire_seen) out_stall = draw_wait(out_calm);
    if (out_stall != 0) begin
      out_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic queue_poll(logic [31:0] now, bit ack, bit srx, logic [7:0] sbyte, bit fc,
                            logic [7:0] b0, logic [19:0] raw_h, logic [19:0] raw_t);
    poll_t p;
    p = '0;
    p.now_ms          = now;
    p.trigger_acked   = ack;
    p.status_received = srx;
    p.status_byte     = sbyte;
    p.frame_complete  = fc;
    p.frame_bytes     = {b0, raw_h, raw_t};
    queued_polls.push_back(p);
    polls_queued++;
  endtask

  task automatic queue_random_polls(int unsigned count, int unsigned fault_pct);
    int unsigned sel;
    int unsigned step;
    logic [7:0]  sbyte;
    logic [7:0]  b0;
    logic [19:0] raw_h;
    logic [19:0] raw_t;
    for (int unsigned i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) step = $urandom_range(0, 40);
      else if (sel < 65) step = $urandom_range(80, 100);
      else if (sel < 90) step = (seq_period < 16'd10) ? $urandom_range(0, 20)
                                : 32'(seq_period) + $urandom_range(0, 20) - 10;
      else if (sel < 97) step = 32'(seq_period) * 10 + 5000 + $urandom_range(0, 2) - 1;
      else begin
        gen_now = $urandom;
        step = 0;
      end
      gen_now = gen_now + step;
      sbyte = 8'($urandom);
      sbyte[BUSY_BIT] = chance(fault_pct);
      b0 = 8'($urandom);
      b0[7] = chance(fault_pct);
      case ($urandom_range(0, 9))
        0: raw_h = '0;
        1: raw_h = '1;
        default: raw_h = 20'($urandom);
      endcase
      if (!chance(fault_pct)) raw_t = 20'($urandom_range(734003, 52429));
      else begin
        case ($urandom_range(0, 4))
          0: raw_t = 20'd52428;
          1: raw_t = 20'd734004;
          2: raw_t = '0;
          3: raw_t = '1;
          default: raw_t = 20'($urandom);
        endcase
      end
      queue_poll(gen_now, !chance(fault_pct), !chance(fault_pct), sbyte, !chance(fault_pct),
                 b0, raw_h, raw_t);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (polls_accepted != polls_queued || awaited_reports.size() != 0);
  endtask

  task automatic write_period(logic [15:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    seq_period  = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [15:0] periods[6];
    int unsigned fault_pct;

    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    in_fire_seen  = 1'b0;
    out_fire_seen = 1'b0;
    in_gap        = 0;
    out_stall     = 0;
    in_calm       = 1'b0;
    out_calm      = 1'b0;
    idle_cycles   = 0;

    seq_period       = PERIOD_RESET;
    seq_measuring    = 1'b0;
    seq_last_request = '0;
    seq_last_good    = '0;
    seq_attempts     = '0;
    seq_failures     = '0;
    seq_healthy      = 1'b0;
    seq_humidity     = '0;
    seq_temperature  = '0;
    seq_has_reading  = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed walk under the reset period
    queue_poll(32'd0,    1, 1, 8'h00, 1, 8'h00, 20'h80000, 20'h60000); // before first period
    queue_poll(32'd1000, 1, 1, 8'h00, 1, 8'h00, 20'h80000, 20'h60000); // trigger
    queue_poll(32'd1050, 1, 1, 8'h00, 1, 8'h00, 20'h80000, 20'h60000); // still settling
    queue_poll(32'd1090, 1, 0, 8'h00, 1, 8'h00, 20'h80000, 20'h60000); // status lost x3
    queue_poll(32'd1091, 1, 0, 8'h00, 1, 8'h00, 20'h80000, 20'h60000);
    queue_poll(32'd1092, 1, 0, 8'h00, 1, 8'h00, 20'h80000, 20'h60000);
    queue_poll(32'd2092, 0, 1, 8'h00, 1, 8'h00, 20'h80000, 20'h60000); // trigger nack
    queue_poll(32'd3092, 1, 1, 8'h00, 1, 8'h00, 20'h80000, 20'h60000);
    queue_poll(32'd3182, 1, 1, 8'h80, 1, 8'h00, 20'h80000, 20'h60000); // sensor busy
    queue_poll(32'd3183, 1, 1, 8'h00, 0, 8'h00, 20'h80000, 20'h60000); // short frame
    queue_poll(32'd4183, 1, 1, 8'h00, 1, 8'h00, 20'h80000, 20'h60000);
    queue_poll(32'd4273, 1, 1, 8'h00, 1, 8'h80, 20'h80000, 20'h60000); // frame busy
    queue_poll(32'd5273, 1, 1, 8'h00, 1, 8'h00, 20'h80000, 20'h60000);
    queue_poll(32'd5363, 1, 1, 8'h00, 1, 8'h00, 20'h80000, 20'd52428); // just too cold
    queue_poll(32'd6363, 0, 1, 8'h00, 1, 8'h00, 20'h80000, 20'h60000); // count saturates
    queue_poll(32'd7363, 1, 1, 8'h00, 1, 8'h00, 20'h80000, 20'h60000);
    queue_poll(32'd7453, 1, 1, 8'h00, 1, 8'h00, 20'h80000, 20'd734004); // just too hot
    queue_poll(32'd8453, 1, 1, 8'h00, 1, 8'h00, 20'h80000, 20'h60000);
    queue_poll(32'd8543, 1, 1, 8'h00, 1, 8'h00, 20'h00000, 20'd52429); // coldest valid
    queue_poll(32'd9543, 1, 1, 8'h00, 1, 8'h00, 20'h80000, 20'h60000);
    queue_poll(32'd9633, 1, 1, 8'h7F, 1, 8'h7F, 20'hFFFFF, 20'd734003); // hottest, wettest
    queue_poll(32'd24634, 0, 1, 8'h00, 1, 8'h00, 20'h80000, 20'h60000); // goes stale
    queue_poll(32'hFFFF_FFFF, 1, 1, 8'hFF, 1, 8'hFF, 20'hFFFFF, 20'hFFFFF);
    queue_poll(32'd89,   1, 1, 8'h00, 1, 8'h00, 20'h12345, 20'h60000); // settle across wrap
    gen_now = 32'd89;
    wait_drained();

    periods[0] = 16'd0;
    periods[1] = 16'hFFFF;
    periods[2] = 16'd1;
    periods[3] = 16'($urandom_range(50, 300));
    periods[4] = PERIOD_RESET;
    periods[5] = 16'($urandom_range(0, 65535));
    foreach (periods[i]) begin
      case ($urandom_range(0, 2))
        0: fault_pct = 3;
        1: fault_pct = 20;
        default: fault_pct = 50;
      endcase
      write_period(periods[i]);
      queue_random_polls(PHASE_POLLS, fault_pct);
      wait_drained();
    end

    repeat (10) @(negedge clk);
    $display("%0d polls, %0d results checked over %0d trigger periods", polls_accepted,
             reports_checked, $size(periods) + 1);
    $display("actions none/trigger/status/frame: %0d/%0d/%0d/%0d, %0d fresh readings, %0d stale",
             action_count[ACT_NONE], action_count[ACT_TRIGGER], action_count[ACT_STATUS],
             action_count[ACT_FRAME], fresh_count, stale_drops);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
